>>> hw/rtl/huffman_tree_decoder_defines.svh
// ---------------------------------------------------------------------------
// Huffman tree decoder assertion macros
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_DECODER_DEFINES_SVH

// same-cycle implication
`define HTD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htd check failed");

// next-cycle implication
`define HTD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("htd check failed");

`endif

>>> hw/rtl/htd_pkg.sv
// ---------------------------------------------------------------------------
// Huffman tree decoder package
// Field widths, command and register codes, shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package htd_pkg;

  localparam int SYM_W       = 8;
  localparam int IDX_FIELD_W = 9;
  localparam int TOTAL_W     = 31;
  localparam int CMD_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 31;
  localparam int BIT_CNT_W   = 4;
  localparam int BYTE_MSB    = 7;

  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // command codes on the request channel
  localparam logic [CMD_W-1:0] CMD_NODE_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DECODE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SYMBOLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_INDEX    = 1'b1;

  typedef enum logic [1:0] {
    OP_NODE_WR,
    OP_DECODE,
    OP_RESTART
  } op_t;

  typedef struct packed {
    logic                   leaf;
    logic [SYM_W-1:0]       sym;
    logic [IDX_FIELD_W-1:0] left;
    logic [IDX_FIELD_W-1:0] right;
  } node_t;

  typedef struct packed {
    op_t                    op;
    logic [IDX_FIELD_W-1:0] node_index;
    node_t                  node;
    logic [BYTE_W-1:0]      data_byte;
  } q_entry_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]     total_symbols;
    logic [IDX_FIELD_W-1:0] root_index;
    logic                   root_wr;
    logic [IDX_FIELD_W-1:0] root_wdata;
  } cfg_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/htd_req_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying node writes, data bytes and restarts.
// ---------------------------------------------------------------------------
`default_nettype none

interface htd_req_if import htd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [IDX_FIELD_W-1:0] node_index;
  logic                   node_is_leaf;
  logic [SYM_W-1:0]       node_symbol;
  logic [IDX_FIELD_W-1:0] left_child;
  logic [IDX_FIELD_W-1:0] right_child;
  logic [BYTE_W-1:0]      data_byte;

  modport source (
    output valid, command, node_index, node_is_leaf, node_symbol,
           left_child, right_child, data_byte,
    input  ready
  );
  modport sink (
    input  valid, command, node_index, node_is_leaf, node_symbol,
           left_child, right_child, data_byte,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/htd_res_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying decoded symbols.
// ---------------------------------------------------------------------------
`default_nettype none

interface htd_res_if import htd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last_in_run;
  logic             stream_done;

  modport source (output valid, symbol, last_in_run, stream_done, input ready);
  modport sink   (input valid, symbol, last_in_run, stream_done, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/htd_cfg_if.sv
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready register write port: register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface htd_cfg_if import htd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/htd_queue.sv
// ---------------------------------------------------------------------------
// Command queue
// Two-entry FIFO between the front and the back of the decoder.
// ---------------------------------------------------------------------------
`default_nettype none

module htd_queue import htd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output q_entry_t head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = 1;
  localparam int LVL_W = 2;

  q_entry_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;
  logic             do_push;
  logic             do_pop;

  assign full    = (level == LVL_W'(DEPTH));
  assign valid   = (level != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/htd_front.sv
// ---------------------------------------------------------------------------
// Decoder front end
// Accepts request items, classifies the command and queues valid ones.
// ---------------------------------------------------------------------------
`default_nettype none

module htd_front import htd_pkg::*; (
  htd_req_if.sink  req,
  input  logic     q_full,
  output logic     q_push,
  output q_entry_t q_entry
);

  logic known;

  assign req.ready = !q_full;

  always_comb begin
    known            = 1'b1;
    q_entry.op       = OP_DECODE;
    q_entry.node_index = req.node_index;
    q_entry.node.leaf  = req.node_is_leaf;
    q_entry.node.sym   = req.node_symbol;
    q_entry.node.left  = req.left_child;
    q_entry.node.right = req.right_child;
    q_entry.data_byte  = req.data_byte;
    unique case (req.command)
      CMD_NODE_WRITE: q_entry.op = OP_NODE_WR;
      CMD_DECODE:     q_entry.op = OP_DECODE;
      CMD_RESTART:    q_entry.op = OP_RESTART;
      default:        known      = 1'b0;   // unknown command: dropped
    endcase
  end

  assign q_push = req.valid && req.ready && known;

endmodule

`default_nettype wire

>>> hw/rtl/htd_back.sv
// ---------------------------------------------------------------------------
// Decoder back end
// Node table, tree walk sequencer and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module htd_back import htd_pkg::*; #(
  parameter int MAX_NODES = 512
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  q_entry_t q_head,
  output logic     q_pop,
  htd_res_if.source res
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam logic [IDX_FIELD_W:0] DEPTH = (IDX_FIELD_W+1)'(MAX_NODES);

  node_t node_mem [MAX_NODES];

  back_state_t            state, state_next;
  logic [IDX_FIELD_W-1:0] walk, walk_next;
  logic [TOTAL_W-1:0]     count, count_next;
  logic [BIT_CNT_W-1:0]   bits, bits_next;
  logic                   pending, pending_next;
  logic [BYTE_W-1:0]      byte_q, byte_q_next;
  logic                   hold_valid, hold_valid_next;
  logic [SYM_W-1:0]       hold_sym, hold_sym_next;
  logic                   hold_done, hold_done_next;
  logic                   out_valid, out_valid_next;
  logic [SYM_W-1:0]       out_sym, out_sym_next;
  logic                   out_last, out_last_next;
  logic                   out_done, out_done_next;
  node_t                  rd_q;
  logic                   rd_ok;

  node_t                  cur;
  logic [IDX_FIELD_W-1:0] child;
  logic                   advance;
  logic                   idle_pop;
  logic                   in_walk;
  logic                   more_bits;
  logic                   finish;
  logic                   do_emit;
  logic                   consume;
  logic                   new_done;
  logic                   wr_en;

  // shared decisions
  always_comb begin
    advance   = !out_valid || res.ready;
    cur       = rd_ok ? rd_q : '0;          // beyond table: internal node, children 0
    child     = byte_q[BYTE_MSB] ? cur.right : cur.left;
    idle_pop  = (state == BK_IDLE) && advance && q_valid;
    in_walk   = (state == BK_WALK) && advance;
    more_bits = (bits != BITS_PER_BYTE) && (count < cfg.total_symbols);
    finish    = in_walk && !pending && !more_bits;
    do_emit   = in_walk && !finish && cur.leaf;
    consume   = in_walk && !finish && (!pending || (!cur.leaf && more_bits));
    new_done  = (({1'b0, count} + (TOTAL_W+1)'(1)) >= {1'b0, cfg.total_symbols});
    wr_en     = idle_pop && (q_head.op == OP_NODE_WR)
                && ({1'b0, q_head.node_index} < DEPTH);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (idle_pop && (q_head.op == OP_DECODE)) begin
          state_next = BK_WALK;
        end
      end
      BK_WALK: begin
        if (finish) begin
          state_next = BK_IDLE;
        end
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop           = idle_pop;
    walk_next       = walk;
    count_next      = count;
    bits_next       = bits;
    pending_next    = pending;
    byte_q_next     = byte_q;
    hold_valid_next = hold_valid;
    hold_sym_next   = hold_sym;
    hold_done_next  = hold_done;
    out_valid_next  = out_valid;
    out_sym_next    = out_sym;
    out_last_next   = out_last;
    out_done_next   = out_done;

    if (advance) begin
      out_valid_next = 1'b0;
    end

    priority if (cfg.root_wr) begin
      walk_next = cfg.root_wdata;
    end else if (idle_pop && (q_head.op == OP_RESTART)) begin
      walk_next = cfg.root_index;
    end else if (do_emit) begin
      walk_next = cfg.root_index;
    end else if (consume && !cur.leaf) begin
      walk_next = child;
    end else begin
      walk_next = walk;
    end

    if (idle_pop && (q_head.op == OP_RESTART)) begin
      count_next = '0;
    end else if (do_emit) begin
      count_next = count + TOTAL_W'(1);
    end

    if (idle_pop && (q_head.op == OP_DECODE)) begin
      bits_next    = '0;
      pending_next = 1'b0;
      byte_q_next  = q_head.data_byte;
    end
    if (consume) begin
      bits_next   = bits + BIT_CNT_W'(1);
      byte_q_next = {byte_q[BYTE_MSB-1:0], 1'b0};
    end
    if (in_walk && !finish) begin
      pending_next = !cur.leaf && (!pending || more_bits);
    end

    // a symbol is held back until the next leaf or the end of its byte so the last of a byte can be flagged
    if (do_emit) begin
      if (hold_valid) begin
        out_valid_next = 1'b1;
        out_sym_next   = hold_sym;
        out_last_next  = 1'b0;
        out_done_next  = hold_done;
      end
      hold_valid_next = 1'b1;
      hold_sym_next   = cur.sym;
      hold_done_next  = new_done;
    end
    if (finish) begin
      if (hold_valid) begin
        out_valid_next = 1'b1;
        out_sym_next   = hold_sym;
        out_last_next  = 1'b1;
        out_done_next  = hold_done;
      end
      hold_valid_next = 1'b0;
    end
  end

  // node table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[q_head.node_index[IDX_W-1:0]] <= q_head.node;
    end
    rd_q  <= node_mem[walk_next[IDX_W-1:0]];
    rd_ok <= ({1'b0, walk_next} < DEPTH);
  end

  always_ff @(posedge clk) begin
    byte_q    <= byte_q_next;
    hold_sym  <= hold_sym_next;
    hold_done <= hold_done_next;
    out_sym   <= out_sym_next;
    out_last  <= out_last_next;
    out_done  <= out_done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      walk       <= '0;
      count      <= '0;
      bits       <= '0;
      pending    <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      walk       <= walk_next;
      count      <= count_next;
      bits       <= bits_next;
      pending    <= pending_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.symbol      = out_sym;
  assign res.last_in_run = out_last;
  assign res.stream_done = out_done;

endmodule

`default_nettype wire

>>> hw/rtl/huffman_tree_decoder.sv
// ---------------------------------------------------------------------------
// Huffman tree decoder
// Walks a software-loaded code tree, one node table read per walk step.
// ---------------------------------------------------------------------------
// req: node write (loads one table entry), decode (up to 8 bits of data_byte,
//   MSB first) or restart (walk to root, count cleared); other codes are
//   dropped. req.ready falls only when the 2-entry queue is full.
// res: one item per symbol, up to 8 per byte; last_in_run marks the last of
//   a byte, stream_done the one that brings the count to total_symbols.
// cfg: writes to 0 total_symbols, 1 root_index, always ready; a root write
//   also moves the walk. Write only while nothing is queued or walking.
// Walk: each step needs the table entry it lands on, read through the single
//   registered read port, so the steps of a byte go one after another. A
//   symbol is held until the next leaf or the end of its byte and reaches
//   res in the cycle after that.
// Reset: control cleared, walk at node 0, count and registers 0; the node
//   table is not cleared. Stall: a held result freezes the back end, the
//   queue fills and req.ready drops; no item is lost.
// ---------------------------------------------------------------------------
`default_nettype none

module huffman_tree_decoder import htd_pkg::*; #(
  parameter int MAX_NODES = 512
) (
  input  logic      clk,
  input  logic      rst,
  htd_req_if.sink   req,
  htd_res_if.source res,
  htd_cfg_if.sink   cfg
);

  logic [TOTAL_W-1:0]     total_symbols;
  logic [IDX_FIELD_W-1:0] root_index;
  logic                   cfg_wr;
  cfg_t                   settings;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_in;
  q_entry_t q_head;

  // config port never stalls
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_symbols <= '0;
      root_index    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        REG_TOTAL_SYMBOLS: total_symbols <= cfg.data[TOTAL_W-1:0];
        REG_ROOT_INDEX:    root_index    <= cfg.data[IDX_FIELD_W-1:0];
      endcase
    end
  end

  // root write goes to the walker in the same cycle as the register
  always_comb begin
    settings.total_symbols = total_symbols;
    settings.root_index    = root_index;
    settings.root_wr       = cfg_wr && (cfg.index == REG_ROOT_INDEX);
    settings.root_wdata    = cfg.data[IDX_FIELD_W-1:0];
  end

  htd_front u_front (
    .req     (req),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  htd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  htd_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (settings),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

`default_nettype wire

>>> hw/rtl/htd_checker.sv
// ---------------------------------------------------------------------------
// Huffman tree decoder checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "huffman_tree_decoder_defines.svh"

module htd_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_symbol,
  input logic       res_last_in_run,
  input logic       res_stream_done
);

  // no result straight out of reset
  `HTD_ASSERT_NXT(a_reset_idle, clk, 1'b0, rst, !res_valid)

  // the count-reaching symbol ends its byte
  `HTD_ASSERT_IMP(a_done_is_last, clk, rst, res_valid && res_stream_done, res_last_in_run)

  // stalled result holds
  `HTD_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_symbol) && $stable(res_last_in_run) && $stable(res_stream_done))

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .res_symbol      (res.symbol),
  .res_last_in_run (res.last_in_run),
  .res_stream_done (res.stream_done)
);

`default_nettype wire
